// ----- design/stsk_pkg.sv -----
// Shared types for the Stirling number (second kind) core.
// Holds the controller state encoding and the command/status bundles.
// No dependencies.
package stsk_pkg;

	localparam int FIELD_W = 9;
	localparam int COUNT_W = 64;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_DONE  = 4'b1000
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;    // latch a new query, restart the band walk
		logic issue;   // advance the cell counter, read the next buffer entry
		logic finish;  // capture the last cell as the result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic query_bad;   // query at the input has no defined result
		logic issue_last;  // cell counter sits on the final cell of the band
	} dp_status_t;

endpackage

// ----- design/stsk_datapath.sv -----
// Datapath: query registers, band cell counters, column buffer memory and
// the multiply-add cell update. Depends on stsk_pkg.
module stsk_datapath #(
	parameter int MAX_N = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stsk_pkg::dp_cmd_t    cmd,
	output stsk_pkg::dp_status_t status,
	input  logic [8:0]           set_size,
	input  logic [8:0]           part_count,
	output logic [63:0]          count_value,
	output logic                 query_valid
);
	import stsk_pkg::*;

	localparam int DEPTH = (MAX_N < 512) ? MAX_N : 512;
	localparam int AW    = $clog2(DEPTH);

	logic [FIELD_W-1:0] k_q;
	logic [AW-1:0]      span_q;
	logic [FIELD_W-1:0] i_q;
	logic [AW-1:0]      d_q;

	logic               cell_vld_s1;
	logic [FIELD_W-1:0] i_s1;
	logic [AW-1:0]      d_s1;

	logic [COUNT_W-1:0] band_mem [DEPTH];
	logic [COUNT_W-1:0] rd_data_q;
	logic [COUNT_W-1:0] prev_q;
	logic [COUNT_W-1:0] cell_val;
	logic [COUNT_W-1:0] result_q;
	logic               result_ok_q;
	logic [FIELD_W-1:0] span_full;

	assign status.query_bad = (part_count == '0) || (set_size == '0) ||
		(part_count > set_size) || (32'(set_size) > MAX_N);
	assign status.issue_last = (i_q == k_q) && (d_q == span_q);

	assign span_full = set_size - part_count;

	// in-place update: new[d] = old[d] + i * new[d-1]
	assign cell_val = ((d_s1 == '0) || (i_s1 == FIELD_W'(1))) ? COUNT_W'(1) :
		rd_data_q + COUNT_W'(prev_q * COUNT_W'(i_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_s1 <= 1'b0;
		end else begin
			cell_vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q    <= part_count;
			span_q <= span_full[AW-1:0];
			i_q    <= FIELD_W'(1);
			d_q    <= '0;
		end else if (cmd.issue) begin
			if (d_q == span_q) begin
				d_q <= '0;
				i_q <= i_q + FIELD_W'(1);
			end else begin
				d_q <= d_q + AW'(1);
			end
		end
		if (cmd.issue) begin
			i_s1 <= i_q;
			d_s1 <= d_q;
		end
		if (cell_vld_s1) begin
			prev_q <= cell_val;
		end
		if (cmd.load) begin
			result_q    <= '0;
			result_ok_q <= 1'b0;
		end else if (cmd.finish) begin
			result_q    <= cell_val;
			result_ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_vld_s1) begin
			band_mem[d_s1] <= cell_val;
		end
		rd_data_q <= band_mem[d_q];
	end

	assign count_value = result_q;
	assign query_valid = result_ok_q;

endmodule

// ----- design/stsk_ctrl.sv -----
// Controller state machine: sequences one query through the band walk
// and holds the result until taken. Depends on stsk_pkg.
module stsk_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  stsk_pkg::dp_status_t status,
	output stsk_pkg::dp_cmd_t    cmd
);
	import stsk_pkg::*;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall  = !((state_q == ST_IDLE) || ((state_q == ST_DONE) && !out_stall));
	assign accept    = in_valid && !in_stall;
	assign out_valid = (state_q == ST_DONE);

	always_comb begin
		cmd.load   = accept;
		cmd.issue  = (state_q == ST_RUN);
		cmd.finish = (state_q == ST_DRAIN);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = status.query_bad ? ST_DONE : ST_RUN;
			end
			ST_RUN: begin
				if (status.issue_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_stall) begin
					if (accept) state_d = status.query_bad ? ST_DONE : ST_RUN;
					else        state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- design/stirling_second_kind_core.sv -----
// A valid query walks the band one cell per cycle through the column buffer's read port
// and the multiply-add, then the final cell is captured as the result; an invalid query
// is answered in the next cycle. Throughput: one query at a time, so the next query
// starts as the result transaction completes.
// Reset: arst_n asynchronous, active low; clears the controller, no result pending.
// The column buffer has no reset: column 1 ignores the read data and writes rows 0..n-k.
module stirling_second_kind_core #(
	parameter int MAX_N = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [8:0]  set_size,
	input  logic [8:0]  part_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] count_value,
	output logic        query_valid
);
	import stsk_pkg::*;

	// Commands drive the datapath: load on an input transaction, issue one
	// band cell per cycle, finish to capture the final cell.
	dp_cmd_t    cmd;
	dp_status_t status;

	// Controller: owns both handshakes and the state sequence.
	stsk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: walks columns i=1..k and rows d=0..n-k, updating the column
	// buffer in place; the result register stays put while out_valid is held.
	stsk_datapath #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.set_size    (set_size),
		.part_count  (part_count),
		.count_value (count_value),
		.query_valid (query_valid)
	);

endmodule

// ----- design/stsk_checker.sv -----
// Port-level checker for the Stirling number core, bound to the top level.
// Depends only on the top level's ports.
module stsk_checker #(
	parameter int MAX_N = 256
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [8:0]  set_size,
	input logic [8:0]  part_count,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] count_value,
	input logic        query_valid
);

	logic in_take;
	logic good_query;

	assign in_take    = in_valid && !in_stall;
	assign good_query = (part_count != 9'd0) && (part_count <= set_size) &&
		(32'(set_size) <= MAX_N);

	// a held result does not change
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(count_value) && $stable(query_valid))
		else $error("result changed while stalled");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !query_valid |-> count_value == 64'd0)
		else $error("invalid result carries a nonzero count");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && good_query |=> in_stall && !out_valid)
		else $error("valid query answered or another taken too early");

	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_take && (part_count == 9'd0) |=> out_valid && !query_valid)
		else $error("empty-block query not rejected at once");

endmodule

bind stirling_second_kind_core stsk_checker #(.MAX_N(MAX_N)) u_stsk_checker (.*);
